/* hdl/bspq_pkg.sv */
// Shared sizes, codes and bus types of the bounded stable priority queue.
// No dependencies; every other file of the block refers to it by scoped names.
package bspq_pkg;

  // Storage sizes.
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 64;

  // Port and count widths.
  localparam int VAL_PORT_W = 64;
  localparam int PRIO_W     = 16;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int STAT_W     = 2;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes of a request.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic op;
  } dp_cmd_t;

endpackage

/* hdl/bspq_if.sv */
// Request and result channel interfaces of the priority queue.
// Depends on bspq_pkg for payload widths.
interface bspq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [bspq_pkg::VAL_PORT_W-1:0]      item_value;
  logic signed [bspq_pkg::PRIO_W-1:0]   item_priority;

  modport source (output valid, output command, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input command, input item_value,
                  input item_priority, output ready);
endinterface

interface bspq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bspq_pkg::STAT_W-1:0]          status;
  logic [bspq_pkg::VAL_PORT_W-1:0]      out_value;
  logic signed [bspq_pkg::PRIO_W-1:0]   out_priority;
  logic [bspq_pkg::CNT_W-1:0]           count;
  logic                                 empty_now;
  logic                                 full_now;

  modport source (output valid, output status, output out_value, output out_priority,
                  output count, output empty_now, output full_now, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input count, input empty_now, input full_now, output ready);
endinterface

/* hdl/bounded_stable_priority_queue_core.sv */
// Bounded stable priority queue: a result is registered and shown in the cycle after
// its request. Accepts one request per cycle while out_ready is high; all slot cells
// compare and shift in parallel in the cycle a request is accepted, and a registered
// result frees the input side. Reset (synchronous, active low) empties the queue and
// sets capacity to 16. Top level; depends on bspq_pkg, bspq_if, bspq_ctrl and bspq_dp.
module bounded_stable_priority_queue_core (
  input  logic              clk,
  input  logic              rst_n,
  bspq_in_if.sink           in_req,
  bspq_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic [bspq_pkg::CAP_W-1:0] cfg_wdata
);

  bspq_pkg::dp_cmd_t cmd;

  // Handshake control.
  bspq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_req.ready),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .cmd        (cmd)
  );

  // Slot cells and result register.
  bspq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .item_value    (in_req.item_value),
    .item_priority (in_req.item_priority),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .res_status    (out_res.status),
    .res_value     (out_res.out_value),
    .res_priority  (out_res.out_priority),
    .res_count     (out_res.count),
    .res_empty     (out_res.empty_now),
    .res_full      (out_res.full_now)
  );

endmodule

/* hdl/bspq_ctrl.sv */
// Handshake controller: accepts requests and tracks the pending result.
// Depends on bspq_pkg for the datapath command type.
module bspq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bspq_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // A new request may enter whenever the result register is free or is being taken.
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  assign cmd.exec = accept;
  assign cmd.op   = in_command;

  // Next state: hold while a result is waiting, otherwise idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/bspq_dp.sv */
// Datapath: sorted slot cells, held count, capacity register and result register.
// Depends on bspq_pkg for sizes, codes and the command type.
module bspq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bspq_pkg::dp_cmd_t                   cmd,
  input  logic [bspq_pkg::VAL_PORT_W-1:0]     item_value,
  input  logic signed [bspq_pkg::PRIO_W-1:0]  item_priority,
  input  logic                                cfg_we,
  input  logic [bspq_pkg::CAP_W-1:0]          cfg_wdata,
  output logic [bspq_pkg::STAT_W-1:0]         res_status,
  output logic [bspq_pkg::VAL_PORT_W-1:0]     res_value,
  output logic signed [bspq_pkg::PRIO_W-1:0]  res_priority,
  output logic [bspq_pkg::CNT_W-1:0]          res_count,
  output logic                                res_empty,
  output logic                                res_full
);

  localparam int D  = bspq_pkg::DEPTH;
  localparam int CW = bspq_pkg::CNT_W;

  // Slot cells, slot 0 at the head; no reset, only slots below the count are read.
  logic [bspq_pkg::VALUE_BITS-1:0]    val_r  [D];
  logic signed [bspq_pkg::PRIO_W-1:0] prio_r [D];
  logic [bspq_pkg::VALUE_BITS-1:0]    val_nxt  [D];
  logic signed [bspq_pkg::PRIO_W-1:0] prio_nxt [D];

  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;
  logic [bspq_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]              lim;
  logic [D-1:0]               keep;
  logic                       do_push;
  logic                       do_pop;
  logic [bspq_pkg::STAT_W-1:0] stat_nxt;

  logic [bspq_pkg::STAT_W-1:0]        status_r;
  logic [bspq_pkg::VAL_PORT_W-1:0]    value_r;
  logic signed [bspq_pkg::PRIO_W-1:0] prio_out_r;
  logic [CW-1:0]                      count_r;
  logic                               empty_r;
  logic                               full_r;

  // Effective limit is the smaller of capacity and depth.
  always_comb begin
    if (int'(cap_r) > D) lim = CW'(D);
    else                 lim = CW'(cap_r);
  end

  // Each cell keeps its entry when it is occupied and not of lower priority.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      keep[i] = (CW'(i) < cnt_r) && (prio_r[i] >= item_priority);
    end
  end

  // Operation decode and status.
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    stat_nxt = bspq_pkg::ST_DONE;
    if (cmd.op == bspq_pkg::CMD_PUSH) begin
      if (cnt_r >= lim) stat_nxt = bspq_pkg::ST_FULL;
      else              do_push  = 1'b1;
    end else begin
      if (cnt_r == '0) stat_nxt = bspq_pkg::ST_EMPTY;
      else             do_pop   = 1'b1;
    end
  end

  // Cell update: keep, take the new entry, or shift from the neighbour.
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < D; i++) begin
      val_nxt[i]  = val_r[i];
      prio_nxt[i] = prio_r[i];
    end
    if (do_push) begin
      cnt_nxt = cnt_r + CW'(1);
      for (int i = 0; i < D; i++) begin
        if (!keep[i]) begin
          if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
            val_nxt[i]  = item_value[bspq_pkg::VALUE_BITS-1:0];
            prio_nxt[i] = item_priority;
          end else begin
            val_nxt[i]  = val_r[(i == 0) ? 0 : i-1];
            prio_nxt[i] = prio_r[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
      for (int i = 0; i < D-1; i++) begin
        val_nxt[i]  = val_r[i+1];
        prio_nxt[i] = prio_r[i+1];
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < D; i++) begin
        val_r[i]  <= val_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
    end
  end

  // Count and capacity registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= bspq_pkg::CAP_RESET;
    end else begin
      if (cmd.exec) cnt_r <= cnt_nxt;
      if (cfg_we)   cap_r <= cfg_wdata;
    end
  end

  // Result register, loaded with each executed request.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= stat_nxt;
      value_r    <= do_pop ? bspq_pkg::VAL_PORT_W'(val_r[0]) : '0;
      prio_out_r <= do_pop ? prio_r[0] : '0;
      count_r    <= cnt_nxt;
      empty_r    <= (cnt_nxt == '0);
      full_r     <= (cnt_nxt >= lim);
    end
  end

  assign res_status   = status_r;
  assign res_value    = value_r;
  assign res_priority = prio_out_r;
  assign res_count    = count_r;
  assign res_empty    = empty_r;
  assign res_full     = full_r;

endmodule
